FILE: rtl/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// shared types and constants of the bakery ticket arbiter
// ----------------------------------------------------------------------------
package bta_pkg;

    // widths fixed by the transaction fields
    localparam int FUNC_W   = 2;
    localparam int AGENT_W  = 4;
    localparam int CNT_W    = 5;
    localparam int OUT_TK_W = 32;

    // most agents that can ever take part, whatever the count register holds
    localparam int MAX_ACTIVE = 16;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_REQUEST = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POLL    = 2'd2;

    // register index of agent_count
    localparam logic REG_AGENT_COUNT = 1'b0;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic               clr;
        logic               take;
        logic [CNT_W-1:0]   idx;
        logic [AGENT_W-1:0] agent;
    } t_scan_ctl;

endpackage

FILE: rtl/bta_ram.sv
// ----------------------------------------------------------------------------
// bta_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bta_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bta_scan.sv
// ----------------------------------------------------------------------------
// bta_scan
// running maximum ticket and bakery-order owner over the scanned entries
// ----------------------------------------------------------------------------
module bta_scan
    import bta_pkg::*;
#(
    parameter int TICKET_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_scan_ctl              i_ctl,
    input  logic                   i_want,
    input  logic [TICKET_BITS-1:0] i_ticket,
    output logic [TICKET_BITS-1:0] o_max,
    output logic                   o_have,
    output logic [AGENT_W-1:0]     o_owner,
    output logic [TICKET_BITS-1:0] o_owner_tk,
    output logic                   o_own_want,
    output logic [TICKET_BITS-1:0] o_own_tk
);

    logic [TICKET_BITS-1:0] r_max;
    logic                   r_have;
    logic [AGENT_W-1:0]     r_owner;
    logic [TICKET_BITS-1:0] r_owner_tk;
    logic                   r_own_want;
    logic [TICKET_BITS-1:0] r_own_tk;
    logic                   w_is_own;

    // the issuing agent is kept aside, it is merged once its new entry is known
    assign w_is_own = (i_ctl.idx == {1'b0, i_ctl.agent});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clr) begin
            r_have <= 1'b0;
        end else if (i_ctl.take && !w_is_own && i_want) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_max      <= '0;
            r_owner    <= '0;
            r_owner_tk <= '0;
            r_own_want <= 1'b0;
            r_own_tk   <= '0;
        end else if (i_ctl.take) begin
            if (i_ticket > r_max) begin
                r_max <= i_ticket;
            end
            if (w_is_own) begin
                r_own_want <= i_want;
                r_own_tk   <= i_ticket;
            end else if (i_want && (!r_have || i_ticket < r_owner_tk)) begin
                // ascending scan: ties stay with the lower number
                r_owner    <= i_ctl.idx[AGENT_W-1:0];
                r_owner_tk <= i_ticket;
            end
        end
    end

    assign o_max      = r_max;
    assign o_have     = r_have;
    assign o_owner    = r_owner;
    assign o_owner_tk = r_owner_tk;
    assign o_own_want = r_own_want;
    assign o_own_tk   = r_own_tk;

endmodule

FILE: rtl/bakery_ticket_arbiter.sv
// ----------------------------------------------------------------------------
// bakery_ticket_arbiter
// the sequencer walks entries 0 .. n-1 in S_SCAN, S_DRAIN waits for the last read,
//   then S_FIN merges, holding while the previous result is unclaimed (n the active agent count;
//   S_FIN follows acceptance directly when n is 0); one transaction at a time, taken only in idle,
//   the walk over the ticket ram reading one entry per cycle through its single read port
// reset: synchronous active low, all flags and tickets read as zero at once,
//   agent_count returns to 16; no clearing pass
// ----------------------------------------------------------------------------
module bakery_ticket_arbiter
    import bta_pkg::*;
#(
    parameter int AGENTS      = 16,
    parameter int TICKET_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [AGENT_W-1:0]    i_agent,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_TK_W-1:0]   o_ticket,
    output logic                  o_may_enter,
    output logic [AGENT_W-1:0]    o_owner,
    output logic                  o_owner_valid,
    output logic                  o_ticket_full
);

    localparam int AW  = $clog2(AGENTS);
    localparam int LIM = (AGENTS < MAX_ACTIVE) ? AGENTS : MAX_ACTIVE;
    localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);
    localparam logic [TICKET_BITS-1:0] TK_MAX = {TICKET_BITS{1'b1}};
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_ACTIVE);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    // configuration register
    logic [CNT_W-1:0]       r_cfg;
    logic                   w_cfg_we;

    // sequencer
    logic [1:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_n;
    logic [FUNC_W-1:0]      r_func;
    logic [AGENT_W-1:0]     r_agent;
    logic [CNT_W-1:0]       w_n_eff;
    logic                   w_accept;

    // ram read pipeline and per-entry written marks
    logic                   r_rd_vld;
    logic [CNT_W-1:0]       r_rd_idx;
    logic [AGENTS-1:0]      r_vld;
    logic [AW-1:0]          w_raddr;
    logic [AW-1:0]          w_rq_addr;
    logic [AW-1:0]          w_waddr;
    logic [TICKET_BITS:0]   w_rdata;
    logic [TICKET_BITS:0]   w_wdata;
    logic                   w_we;
    logic                   w_entry_ok;
    logic                   w_rd_want;
    logic [TICKET_BITS-1:0] w_rd_tk;

    // scan results
    t_scan_ctl              w_ctl;
    logic [TICKET_BITS-1:0] w_max;
    logic                   w_have;
    logic [AGENT_W-1:0]     w_best;
    logic [TICKET_BITS-1:0] w_best_tk;
    logic                   w_own_want;
    logic [TICKET_BITS-1:0] w_own_tk;

    // final merge
    logic                   w_active;
    logic                   w_sat;
    logic                   w_new_want;
    logic [TICKET_BITS-1:0] w_new_tk;
    logic                   w_wins;
    logic                   w_out_free;
    logic                   w_fin_go;

    // result register
    logic                   r_o_valid;
    logic [OUT_TK_W-1:0]    r_ticket;
    logic                   r_may_enter;
    logic [AGENT_W-1:0]     r_owner;
    logic                   r_owner_valid;
    logic                   r_ticket_full;

    // ------------------------------------------------------------------------
    // configuration port, register 0 only, byte lanes ignored
    // ------------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_AGENT_COUNT);
    assign prdata   = (paddr[2] == REG_AGENT_COUNT) ? {{(32-CNT_W){1'b0}}, r_cfg} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CNT_RESET;
        end else if (w_cfg_we) begin
            r_cfg <= pwdata[CNT_W-1:0];
        end
    end

    // effective count, limited by the build and by the agent field
    assign w_n_eff = (r_cfg > LIM_C) ? LIM_C : r_cfg;

    // ------------------------------------------------------------------------
    // sequencer: walk entries 0 .. n-1, wait for the last read, then merge
    // ------------------------------------------------------------------------
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_fin_go   = (r_state == S_FIN) && w_out_free;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (w_accept) begin
                    // with no active agent there is nothing to read
                    n_state = (w_n_eff == '0) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == r_n - 1'b1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold here while the previous result is still unclaimed
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rd_vld <= (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (w_accept) begin
            r_func  <= i_func;
            r_agent <= i_agent;
            r_n     <= w_n_eff;
        end
    end

    // ------------------------------------------------------------------------
    // ticket ram: {wanting, ticket} per agent
    // the write in the merge cycle always lands before the next walk starts,
    // so reads never overlap a pending write to the same entry
    // ------------------------------------------------------------------------
    assign w_raddr   = AW'(r_idx);
    assign w_rq_addr = AW'(r_rd_idx);
    assign w_waddr   = AW'(r_agent);

    bta_ram #(
        .WIDTH (TICKET_BITS + 1),
        .DEPTH (AGENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (r_state == S_SCAN),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // entries never written since reset read as not wanting, ticket zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[w_waddr] <= 1'b1;
        end
    end

    assign w_entry_ok = r_vld[w_rq_addr];
    assign w_rd_want  = w_entry_ok && w_rdata[TICKET_BITS];
    assign w_rd_tk    = w_entry_ok ? w_rdata[TICKET_BITS-1:0] : '0;

    // ------------------------------------------------------------------------
    // scan unit
    // ------------------------------------------------------------------------
    assign w_ctl.clr   = w_accept;
    assign w_ctl.take  = r_rd_vld;
    assign w_ctl.idx   = r_rd_idx;
    assign w_ctl.agent = r_agent;

    bta_scan #(
        .TICKET_BITS (TICKET_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_want     (w_rd_want),
        .i_ticket   (w_rd_tk),
        .o_max      (w_max),
        .o_have     (w_have),
        .o_owner    (w_best),
        .o_owner_tk (w_best_tk),
        .o_own_want (w_own_want),
        .o_own_tk   (w_own_tk)
    );

    // ------------------------------------------------------------------------
    // merge: new entry of the issuing agent against the best of the others
    // ------------------------------------------------------------------------
    assign w_active = ({1'b0, r_agent} < r_n);
    assign w_sat    = (w_max == TK_MAX);

    always_comb begin
        case (r_func)
            FN_REQUEST: begin
                w_new_want = 1'b1;
                w_new_tk   = w_sat ? TK_MAX : w_max + 1'b1;
            end
            FN_RELEASE: begin
                w_new_want = 1'b0;
                w_new_tk   = w_own_tk;
            end
            default: begin
                // poll, and the spare code, leave the entry as it is
                w_new_want = w_own_want;
                w_new_tk   = w_own_tk;
            end
        endcase
    end

    assign w_wins = w_active && w_new_want &&
                    (!w_have || (w_new_tk < w_best_tk) ||
                     ((w_new_tk == w_best_tk) && (r_agent < w_best)));

    assign w_we    = w_fin_go && w_active &&
                     ((r_func == FN_REQUEST) || (r_func == FN_RELEASE));
    assign w_wdata = {w_new_want, w_new_tk};

    // ------------------------------------------------------------------------
    // result register, loaded as the merge completes
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_ticket      <= w_active ? OUT_TK_W'(w_new_tk) : '0;
            r_may_enter   <= w_wins;
            r_owner_valid <= w_have || (w_active && w_new_want);
            r_owner       <= w_wins ? r_agent : (w_have ? w_best : '0);
            r_ticket_full <= w_active && (r_func == FN_REQUEST) && w_sat;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_ticket      = r_ticket;
    assign o_may_enter   = r_may_enter;
    assign o_owner       = r_owner;
    assign o_owner_valid = r_owner_valid;
    assign o_ticket_full = r_ticket_full;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // an accepted transaction always starts the walk or the merge
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted transaction did not leave idle");

    // the walk never addresses an entry beyond the active count
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_n))
        else $error("ticket walk ran past the active count");

    // no read data arrives while the sequencer is idle
    a_no_stray_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rd_vld)
        else $error("ram read still in flight in idle");

    // a written entry is marked valid from then on
    a_write_marks_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_vld[$past(w_waddr)])
        else $error("written entry not marked valid");

    // an agent allowed in implies there is an owner
    a_enter_has_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_may_enter) |-> r_owner_valid)
        else $error("may_enter without owner");

endmodule

FILE: verif/bakery_ticket_arbiter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bakery_ticket_arbiter_tb
// self-checking bench for the bakery ticket arbiter: a short directed plan
// walks the operations and the corner cases of the agent count, then random
// request / poll / release traffic shaped like real lock usage is checked
// transaction by transaction against a behavioural predictor, with random
// gaps on both channels and the agent count changed between phases
// ----------------------------------------------------------------------------
module bakery_ticket_arbiter_tb;
    import bta_pkg::*;

    // narrow tickets so that saturation is reached within the run
    localparam int TKB = 9;
    localparam logic [TKB-1:0] TK_MAX = {TKB{1'b1}};

    // the spare operation code, expected to act as a poll
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

    // byte address of the count register
    localparam logic [2:0] CNT_ADDR = 3'({REG_AGENT_COUNT, 2'b00});

    // cycles of the long hold-off on the result side
    localparam int HOLD_CYCLES = 400;

    // one result transaction
    typedef struct packed {
        logic [OUT_TK_W-1:0] ticket;
        logic                may_enter;
        logic [AGENT_W-1:0]  owner;
        logic                owner_ok;
        logic                full;
    } t_grant;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // one line of the directed plan
    typedef struct {
        t_row_kind          kind;
        logic [FUNC_W-1:0]  fn;
        logic [AGENT_W-1:0] ag;
        logic [CNT_W-1:0]   cnt;
        bit                 typed;
        t_grant             grant;
    } t_plan_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [FUNC_W-1:0]   i_func;
    logic [AGENT_W-1:0]  i_agent;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [OUT_TK_W-1:0] o_ticket;
    logic                o_may_enter;
    logic [AGENT_W-1:0]  o_owner;
    logic                o_owner_valid;
    logic                o_ticket_full;

    // predictor state: flags, tickets and the count register
    logic                want_q [MAX_ACTIVE];
    logic [TKB-1:0]      tk_q   [MAX_ACTIVE];
    logic [CNT_W-1:0]    count_q;
    logic [AGENT_W-1:0]  owner_q;
    logic                owner_ok_q;

    t_grant              grant_q [$];
    int                  mismatches;
    bit                  calm;
    bit                  hold_req;

    bakery_ticket_arbiter #(
        .AGENTS      (MAX_ACTIVE),
        .TICKET_BITS (TKB)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_agent       (i_agent),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ticket      (o_ticket),
        .o_may_enter   (o_may_enter),
        .o_owner       (o_owner),
        .o_owner_valid (o_owner_valid),
        .o_ticket_full (o_ticket_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // generous cap on the whole run
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // number of agents actually taking part
    function automatic int active_agents();
        return (count_q > CNT_W'(MAX_ACTIVE)) ? MAX_ACTIVE : int'(count_q);
    endfunction

    // bakery behaviour of one transaction: updates flags and tickets and
    // returns the grant that the block should report
    function automatic t_grant arbitrate(input logic [FUNC_W-1:0] fn,
                                         input logic [AGENT_W-1:0] ag);
        t_grant         r;
        int             n;
        logic [TKB-1:0] top;
        int             own;
        bit             found;
        r     = '0;
        n     = active_agents();
        own   = 0;
        found = 1'b0;
        if (int'(ag) < n) begin
            if (fn == FN_REQUEST) begin
                want_q[ag] = 1'b1;
                top = '0;
                for (int i = 0; i < n; i++)
                    if (tk_q[i] > top) top = tk_q[i];
                if (top == TK_MAX) begin
                    tk_q[ag] = TK_MAX;
                    r.full   = 1'b1;
                end else begin
                    tk_q[ag] = top + 1'b1;
                end
            end else if (fn == FN_RELEASE) begin
                want_q[ag] = 1'b0;
            end
            r.ticket = OUT_TK_W'(tk_q[ag]);
        end
        // lowest ticket wins, ascending scan keeps the lower number on a tie
        for (int i = 0; i < n; i++) begin
            if (want_q[i] && (!found || tk_q[i] < tk_q[own])) begin
                own   = i;
                found = 1'b1;
            end
        end
        r.owner_ok  = found;
        r.owner     = found ? AGENT_W'(own) : '0;
        r.may_enter = (int'(ag) < n) && want_q[ag] && (own == int'(ag));
        owner_q     = r.owner;
        owner_ok_q  = found;
        return r;
    endfunction

    // mostly short gaps, a few long ones, none at all in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // offer one request transaction and return at the edge that takes it
    task automatic offer(input logic [FUNC_W-1:0] fn, input logic [AGENT_W-1:0] ag);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= fn;
        i_agent    <= ag;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
    endtask

    // stop offering and wait until every expected grant has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
    endtask

    // apb write of the agent count with junk in the unused bits, then read back
    task automatic write_count(input logic [CNT_W-1:0] v);
        logic [31:0] wd;
        wd            = $urandom;
        wd[CNT_W-1:0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CNT_ADDR;
        pwdata  <= wd;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        if (prdata !== 32'(v)) begin
            $error("agent_count: expected %0d, got %0d", v, prdata);
            mismatches++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        count_q = v;
    endtask

    // random traffic shaped like lock usage: request, poll until granted,
    // release; a tenth of it is plain noise
    task automatic pick_item(output logic [FUNC_W-1:0] fn, output logic [AGENT_W-1:0] ag);
        int n;
        int r;
        n = active_agents();
        if (n > 0 && $urandom_range(0, 9) != 0) ag = AGENT_W'($urandom_range(0, n - 1));
        else ag = AGENT_W'($urandom_range(0, MAX_ACTIVE - 1));
        r = $urandom_range(0, 99);
        if (r < 10) begin
            fn = FUNC_W'($urandom_range(0, 3));
        end else if (int'(ag) < n && want_q[ag]) begin
            if (owner_ok_q && owner_q == ag) fn = (r < 75) ? FN_RELEASE : FN_POLL;
            else if (r < 80) fn = FN_POLL;
            else if (r < 92) fn = FN_RELEASE;
            else fn = FN_REQUEST;
        end else begin
            if (r < 78) fn = FN_REQUEST;
            else if (r < 90) fn = FN_POLL;
            else if (r < 96) fn = FN_RELEASE;
            else fn = FN_SPARE;
        end
    endtask

    function automatic t_plan_row cfg_row(input logic [CNT_W-1:0] v);
        t_plan_row p;
        p       = '{kind: ROW_CFG, default: '0};
        p.cnt   = v;
        return p;
    endfunction

    function automatic t_plan_row item_row(input logic [FUNC_W-1:0] fn,
                                           input logic [AGENT_W-1:0] ag);
        t_plan_row p;
        p       = '{kind: ROW_ITEM, default: '0};
        p.fn    = fn;
        p.ag    = ag;
        return p;
    endfunction

    // directed row with its grant typed in (never saturated here)
    function automatic t_plan_row chk_row(input logic [FUNC_W-1:0] fn,
                                          input logic [AGENT_W-1:0] ag,
                                          input int tk, input bit me,
                                          input int own, input bit ok);
        t_plan_row p;
        p       = item_row(fn, ag);
        p.typed = 1'b1;
        p.grant = '{OUT_TK_W'(tk), me, AGENT_W'(own), ok, 1'b0};
        return p;
    endfunction

    // result side: random back-pressure, one long hold-off on request,
    // every transaction compared with the oldest expected grant
    initial begin : result_sink
        int     g;
        t_grant exp_g;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            g = pick_gap();
            if (hold_req) begin
                hold_req = 1'b0;
                g        = HOLD_CYCLES;
            end
            if (g > 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(negedge i_clk); while (!o_out_valid);
            if (grant_q.size() == 0) begin
                $error("result transaction with no grant expected");
                mismatches++;
            end else begin
                exp_g = grant_q.pop_front();
                if (o_ticket !== exp_g.ticket) begin
                    $error("ticket: expected %0d, got %0d", exp_g.ticket, o_ticket);
                    mismatches++;
                end
                if (o_may_enter !== exp_g.may_enter) begin
                    $error("may_enter: expected %0b, got %0b", exp_g.may_enter, o_may_enter);
                    mismatches++;
                end
                if (o_owner !== exp_g.owner) begin
                    $error("owner: expected %0d, got %0d", exp_g.owner, o_owner);
                    mismatches++;
                end
                if (o_owner_valid !== exp_g.owner_ok) begin
                    $error("owner_valid: expected %0b, got %0b", exp_g.owner_ok,
                           o_owner_valid);
                    mismatches++;
                end
                if (o_ticket_full !== exp_g.full) begin
                    $error("ticket_full: expected %0b, got %0b", exp_g.full, o_ticket_full);
                    mismatches++;
                end
            end
            @(posedge i_clk);
        end
    end

    // stimulus
    initial begin : stimulus
        t_plan_row          plan [$];
        int                 phase_cnt [10];
        int                 phase_len;
        int                 issued;
        int                 w;
        logic [FUNC_W-1:0]  fn;
        logic [AGENT_W-1:0] ag;
        t_grant             pred;

        // every input known from time zero
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_in_valid  <= 1'b0;
        i_func      <= FN_POLL;
        i_agent     <= '0;
        i_out_ready <= 1'b0;
        mismatches  = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        issued      = 0;

        // predictor out of reset
        for (int i = 0; i < MAX_ACTIVE; i++) begin
            want_q[i] = 1'b0;
            tk_q[i]   = '0;
        end
        count_q    = CNT_W'(16);
        owner_q    = '0;
        owner_ok_q = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan: fresh state, ordering, spare code, count corners
        plan.push_back(chk_row(FN_POLL,    4'd0,  0, 1'b0,  0, 1'b0));  // nobody flagged
        plan.push_back(chk_row(FN_REQUEST, 4'd15, 1, 1'b1, 15, 1'b1));  // top agent first
        plan.push_back(chk_row(FN_REQUEST, 4'd0,  2, 1'b0, 15, 1'b1));
        plan.push_back(chk_row(FN_SPARE,   4'd0,  2, 1'b0, 15, 1'b1));  // acts as a poll
        plan.push_back(chk_row(FN_RELEASE, 4'd15, 1, 1'b0,  0, 1'b1));  // ticket kept
        plan.push_back(chk_row(FN_POLL,    4'd0,  2, 1'b1,  0, 1'b1));
        plan.push_back(chk_row(FN_RELEASE, 4'd0,  2, 1'b0,  0, 1'b0));
        plan.push_back(cfg_row(5'd0));                                  // everyone inactive
        plan.push_back(chk_row(FN_REQUEST, 4'd0,  0, 1'b0,  0, 1'b0));
        plan.push_back(cfg_row(5'd31));                                 // limited to sixteen
        plan.push_back(chk_row(FN_REQUEST, 4'd3,  3, 1'b1,  3, 1'b1));
        plan.push_back(chk_row(FN_REQUEST, 4'd3,  4, 1'b1,  3, 1'b1));
        plan.push_back(cfg_row(5'd1));                                  // agent 3 left out
        plan.push_back(chk_row(FN_POLL,    4'd3,  0, 1'b0,  0, 1'b0));
        plan.push_back(chk_row(FN_REQUEST, 4'd0,  3, 1'b1,  0, 1'b1));
        plan.push_back(cfg_row(5'd16));                                 // agent 3 back in
        plan.push_back(chk_row(FN_POLL,    4'd3,  4, 1'b0,  0, 1'b1));
        plan.push_back(chk_row(FN_REQUEST, 4'd15, 5, 1'b0,  0, 1'b1));
        plan.push_back(chk_row(FN_RELEASE, 4'd0,  3, 1'b0,  3, 1'b1));
        plan.push_back(chk_row(FN_POLL,    4'd3,  4, 1'b1,  3, 1'b1));
        plan.push_back(cfg_row(5'd15));                                 // top agent inactive
        plan.push_back(item_row(FN_REQUEST, 4'd15));
        plan.push_back(item_row(FN_SPARE,   4'd14));
        plan.push_back(item_row(FN_RELEASE, 4'd3));
        plan.push_back(cfg_row(5'd16));

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                drain();
                write_count(plan[k].cnt);
            end else begin
                offer(plan[k].fn, plan[k].ag);
                pred = arbitrate(plan[k].fn, plan[k].ag);
                grant_q.push_back(plan[k].typed ? plan[k].grant : pred);
            end
        end

        // random phases, each under its own agent count
        phase_cnt = '{16, 31, 5, 1, 16, 0, 12, 2, 16, 9};
        foreach (phase_cnt[p]) begin
            drain();
            write_count(CNT_W'(phase_cnt[p]));
            phase_len = (phase_cnt[p] == 0) ? 25 : (phase_cnt[p] == 1) ? 100 : 250;
            for (int j = 0; j < phase_len; j++) begin
                // calm stretches with no idling on either side
                calm = (issued % 400) < 60;
                // result side holds off while requests keep coming
                if (issued == 150) hold_req = 1'b1;
                // requests pause until every grant is back
                if (issued == 1100) drain();
                pick_item(fn, ag);
                offer(fn, ag);
                grant_q.push_back(arbitrate(fn, ag));
                issued++;
            end
        end
        calm = 1'b0;

        // wind down: wait for the last grants, then a little longer for strays
        i_in_valid <= 1'b0;
        w = 0;
        while (grant_q.size() != 0 && w < 20000) begin
            @(posedge i_clk);
            w++;
        end
        repeat (40) @(posedge i_clk);
        if (grant_q.size() != 0) begin
            $error("%0d grants never came back", grant_q.size());
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/bta_pkg.sv
rtl/bta_ram.sv
rtl/bta_scan.sv
rtl/bakery_ticket_arbiter.sv
verif/bakery_ticket_arbiter_tb.sv
